// ===== design/dad_pkg.sv =====
// dad_pkg: shared types and constants for the detection anchor decoder.
// Used by the core, dad_front, dad_queue and dad_back; depends on nothing.
package dad_pkg;

  localparam int MAX_ANCHORS_DEF = 16384;
  localparam int MAX_CLASSES_DEF = 255;
  localparam int QUEUE_DEPTH     = 4;
  localparam int BOX_ELEMS       = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_W     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_H     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_W     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_H     = 3'd6;

  typedef struct packed {
    logic        mode;
    logic [7:0]  num_classes;
    logic [15:0] conf_threshold;
    logic [23:0] ratio_width;
    logic [23:0] ratio_height;
    logic [16:0] image_width;
    logic [16:0] image_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:           1'b0,
    num_classes:    8'd80,
    conf_threshold: 16'd16384,
    ratio_width:    24'd65536,
    ratio_height:   24'd65536,
    image_width:    17'd10240,
    image_height:   17'd10240
  };

  // One finished anchor handed from front to back.
  typedef struct packed {
    logic [13:0]        anchor;
    logic [7:0]         label;
    logic [15:0]        best;
    logic [15:0]        obj;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] w;
    logic signed [19:0] h;
  } rec_t;

endpackage

// ===== design/dad_in_if.sv =====
// dad_in_if: input channel of the anchor decoder, one element word per beat.
// Standalone; no dependencies.
interface dad_in_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] value;
  logic               frame_start;

  modport source (output valid, output value, output frame_start, input ready);
  modport sink   (input valid, input value, input frame_start, output ready);
endinterface

// ===== design/dad_out_if.sv =====
// dad_out_if: detection channel of the anchor decoder, one detection per word.
// Standalone; no dependencies.
interface dad_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] anchor_index;
  logic [7:0]  label;
  logic [15:0] score;
  logic [16:0] left;
  logic [16:0] top;
  logic [16:0] right;
  logic [16:0] bottom;

  modport source (output valid, output anchor_index, output label, output score,
                  output left, output top, output right, output bottom, input ready);
  modport sink   (input valid, input anchor_index, input label, input score,
                  input left, input top, input right, input bottom, output ready);
endinterface

// ===== design/detection_anchor_decode_core.sv =====
// detection_anchor_decode_core: streaming detector output decoder, top level.
// Throughput: one element word per cycle while the anchor queue is not full; at most one detection per anchor.
// A record enters the anchor queue on the anchor's last class word, then passes the s1, s2 and output registers.
// Front and back are decoupled by a 4-entry anchor queue; input stalls only when it is full.
// Reset (rst_ni, async, active low) clears counters, best class, queue and pipeline valids
// and loads the register defaults. Depends on dad_pkg, dad_in_if, dad_out_if, submodules.
module detection_anchor_decode_core
  import dad_pkg::*;
#(
  parameter int MAX_ANCHORS = MAX_ANCHORS_DEF,
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dad_in_if.sink                in_ch,
  dad_out_if.source             out_ch
);

  cfg_t cfg_q;
  logic push, full, pop, empty;
  rec_t rec_in, rec_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:        cfg_q.mode           <= cfg_data_i[0];
        REG_NUM_CLASSES: cfg_q.num_classes    <= cfg_data_i[7:0];
        REG_CONF_THRESH: cfg_q.conf_threshold <= cfg_data_i[15:0];
        REG_RATIO_W:     cfg_q.ratio_width    <= cfg_data_i[23:0];
        REG_RATIO_H:     cfg_q.ratio_height   <= cfg_data_i[23:0];
        REG_IMAGE_W:     cfg_q.image_width    <= cfg_data_i[16:0];
        REG_IMAGE_H:     cfg_q.image_height   <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  dad_front #(
    .MAX_ANCHORS (MAX_ANCHORS),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_ch  (in_ch),
    .full_i (full),
    .push_o (push),
    .rec_o  (rec_in)
  );

  dad_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rec_o   (rec_out)
  );

  dad_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .rec_i   (rec_out),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== design/dad_front.sv =====
// dad_front: accepts element words, tracks position in the anchor, keeps the
// box, objectness and running best class. Depends on dad_pkg, dad_in_if.
module dad_front
  import dad_pkg::*;
#(
  parameter int MAX_ANCHORS = MAX_ANCHORS_DEF,
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  dad_in_if.sink      in_ch,
  input  logic        full_i,
  output logic        push_o,
  output rec_t        rec_o
);

  localparam int AW     = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
  localparam int MC_CAP = (MAX_CLASSES > 255) ? 255 : MAX_CLASSES;

  function automatic logic [15:0] clip_score(input logic signed [19:0] v);
    logic [15:0] r;
    if (v[19]) begin
      r = 16'd0;
    end else if (v[18:16] != 3'd0) begin
      r = 16'hFFFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic [8:0]         pos_q, pos_d;
  logic [AW-1:0]      anc_q, anc_d;
  logic [15:0]        best_q, best_d;
  logic [7:0]         bcls_q, bcls_d;
  logic signed [19:0] x_q, y_q, w_q, h_q;
  logic [15:0]        obj_q;

  logic               acc;
  logic [8:0]         p, first, c;
  logic [AW-1:0]      a, a_nx;
  logic [AW+13:0]     a_ext;
  logic [7:0]         nc_eff;
  logic [15:0]        sc, cur_best;
  logic [7:0]         cur_cls;
  logic               is_box, is_obj, is_last, upd;

  assign in_ch.ready = !full_i;
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    p      = in_ch.frame_start ? 9'd0 : pos_q;
    a      = in_ch.frame_start ? '0 : anc_q;
    a_nx   = (32'(a) + 32'd1 >= 32'(MAX_ANCHORS)) ? '0 : a + 1'b1;
    a_ext  = {14'd0, a};
    first  = 9'(BOX_ELEMS) + {8'd0, cfg_i.mode};
    c      = p - first;
    sc     = clip_score(in_ch.value);
    if (cfg_i.num_classes == 8'd0) begin
      nc_eff = 8'd1;
    end else if (cfg_i.num_classes > 8'(MC_CAP)) begin
      nc_eff = 8'(MC_CAP);
    end else begin
      nc_eff = cfg_i.num_classes;
    end
    is_box   = p < 9'(BOX_ELEMS);
    is_obj   = !is_box && (p < first);
    upd      = (c == 9'd0) || (sc > best_q);
    cur_best = upd ? sc : best_q;
    cur_cls  = upd ? c[7:0] : bcls_q;
    is_last  = !is_box && !is_obj && (({1'b0, c} + 10'd1) >= {2'b00, nc_eff});
  end

  always_comb begin
    pos_d  = pos_q;
    anc_d  = anc_q;
    best_d = best_q;
    bcls_d = bcls_q;
    if (acc) begin
      anc_d = a;
      priority if (is_box || is_obj) begin
        pos_d = p + 9'd1;
      end else if (!is_last) begin
        pos_d  = p + 9'd1;
        best_d = cur_best;
        bcls_d = cur_cls;
      end else begin
        pos_d  = 9'd0;
        anc_d  = a_nx;
        best_d = 16'd0;
        bcls_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 9'd0;
      anc_q  <= '0;
      best_q <= 16'd0;
      bcls_q <= 8'd0;
    end else begin
      pos_q  <= pos_d;
      anc_q  <= anc_d;
      best_q <= best_d;
      bcls_q <= bcls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_box) begin
      unique case (p[1:0])
        2'd0: x_q <= in_ch.value;
        2'd1: y_q <= in_ch.value;
        2'd2: w_q <= in_ch.value;
        2'd3: h_q <= in_ch.value;
      endcase
    end
    if (acc && is_obj) begin
      obj_q <= sc;
    end
  end

  assign push_o = acc && is_last;

  always_comb begin
    rec_o.anchor = a_ext[13:0];
    rec_o.label  = cur_cls;
    rec_o.best   = cur_best;
    rec_o.obj    = obj_q;
    rec_o.x      = x_q;
    rec_o.y      = y_q;
    rec_o.w      = w_q;
    rec_o.h      = h_q;
  end

`ifndef ASSERT_OFF
  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> pos_q == 9'd0)
    else $error("element position not cleared after anchor end");
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_ch.frame_start) |=> (32'(anc_q) <= 32'd1))
    else $error("anchor count not restarted on frame start");
`endif

endmodule

// ===== design/dad_queue.sv =====
// dad_queue: short anchor queue between front and back.
// Depends on dad_pkg.
module dad_queue
  import dad_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output rec_t rec_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  rec_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == (PW + 1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW + 1)'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== design/dad_back.sv =====
// dad_back: score, threshold, box scaling and clamping pipeline with output
// register. Depends on dad_pkg, dad_out_if.
module dad_back
  import dad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        empty_i,
  input  rec_t        rec_i,
  output logic        pop_o,
  dad_out_if.source   out_ch
);

  function automatic logic [16:0] clamp_box(input logic signed [46:0] prod,
                                            input logic [16:0] lim);
    logic [16:0] r;
    if (prod[46] || (prod == '0)) begin
      r = 17'd0;
    end else if (prod[45:17] > {12'd0, lim}) begin
      r = lim;
    end else begin
      r = prod[33:17];
    end
    return r;
  endfunction

  logic               out_en, s2_en, s1_en;
  logic               s1_v_q, s2_v_q, out_v_q;

  logic [13:0]        s1_anc_q, s2_anc_q;
  logic [7:0]         s1_cls_q, s2_cls_q;
  logic [15:0]        s1_sc_q, s2_sc_q, sc_d;
  logic [31:0]        sc_prod;
  logic signed [21:0] s1_l_q, s1_r_q, s1_t_q, s1_b_q;
  logic signed [21:0] l_d, r_d, t_d, b_d;
  logic signed [46:0] s2_l_q, s2_r_q, s2_t_q, s2_b_q;
  logic               pass;

  logic [13:0]        o_anc_q;
  logic [7:0]         o_cls_q;
  logic [15:0]        o_sc_q;
  logic [16:0]        o_l_q, o_t_q, o_r_q, o_b_q;

  assign out_en = !out_v_q || out_ch.ready;
  assign s2_en  = !s2_v_q || out_en;
  assign s1_en  = !s1_v_q || s2_en;
  assign pop_o  = !empty_i && s1_en;

  always_comb begin
    sc_prod = 32'(rec_i.best) * 32'(rec_i.obj);
    sc_d    = cfg_i.mode ? sc_prod[31:16] : rec_i.best;
    l_d = $signed({rec_i.x[19], rec_i.x, 1'b0}) - $signed({{2{rec_i.w[19]}}, rec_i.w});
    r_d = $signed({rec_i.x[19], rec_i.x, 1'b0}) + $signed({{2{rec_i.w[19]}}, rec_i.w});
    t_d = $signed({rec_i.y[19], rec_i.y, 1'b0}) - $signed({{2{rec_i.h[19]}}, rec_i.h});
    b_d = $signed({rec_i.y[19], rec_i.y, 1'b0}) + $signed({{2{rec_i.h[19]}}, rec_i.h});
  end

  assign pass = s1_sc_q >= cfg_i.conf_threshold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_q <= pop_o;
      end
      if (s2_en) begin
        s2_v_q <= s1_v_q && pass;
      end
      if (out_en) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_anc_q <= rec_i.anchor;
      s1_cls_q <= rec_i.label;
      s1_sc_q  <= sc_d;
      s1_l_q   <= l_d;
      s1_r_q   <= r_d;
      s1_t_q   <= t_d;
      s1_b_q   <= b_d;
    end
    if (s2_en) begin
      s2_anc_q <= s1_anc_q;
      s2_cls_q <= s1_cls_q;
      s2_sc_q  <= s1_sc_q;
      s2_l_q   <= 47'(s1_l_q) * 47'($signed({1'b0, cfg_i.ratio_width}));
      s2_r_q   <= 47'(s1_r_q) * 47'($signed({1'b0, cfg_i.ratio_width}));
      s2_t_q   <= 47'(s1_t_q) * 47'($signed({1'b0, cfg_i.ratio_height}));
      s2_b_q   <= 47'(s1_b_q) * 47'($signed({1'b0, cfg_i.ratio_height}));
    end
    if (out_en) begin
      o_anc_q <= s2_anc_q;
      o_cls_q <= s2_cls_q;
      o_sc_q  <= s2_sc_q;
      o_l_q   <= clamp_box(s2_l_q, cfg_i.image_width);
      o_r_q   <= clamp_box(s2_r_q, cfg_i.image_width);
      o_t_q   <= clamp_box(s2_t_q, cfg_i.image_height);
      o_b_q   <= clamp_box(s2_b_q, cfg_i.image_height);
    end
  end

  assign out_ch.valid        = out_v_q;
  assign out_ch.anchor_index = o_anc_q;
  assign out_ch.label        = o_cls_q;
  assign out_ch.score        = o_sc_q;
  assign out_ch.left         = o_l_q;
  assign out_ch.top          = o_t_q;
  assign out_ch.right        = o_r_q;
  assign out_ch.bottom       = o_b_q;

endmodule
